@@ rtl/core/srsi_pkg.sv @@
// Shared types and constants for the stochastic RSI block.
// Used by the front end, the back end, the top level and the checker.
package srsi_pkg;

  localparam int AVG_BITS   = 48;   // smoothed average width
  localparam int RSI_W      = 23;   // RSI in Q7.16
  localparam int RSI_FRAC   = 16;
  localparam int OUT_W      = 17;   // result in Q1.16
  localparam int STEP_W     = 6;    // divider step counter
  localparam int PERIOD_W   = 7;
  localparam int MIN_PERIOD = 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [6:0]          RSI_PCT      = 7'd100;
  localparam logic [RSI_W-1:0]    RSI_HALF     = 23'd3276800;  // 50.0 in Q7.16
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;
  localparam logic                REG_PERIOD   = 1'b0;         // register index

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ACCUM  = 2'd1,
    OP_SEED   = 2'd2,
    OP_SMOOTH = 2'd3
  } srsi_op_e;

  typedef struct packed {
    srsi_op_e op;
    logic     emit;
  } srsi_ctl_t;

endpackage

@@ rtl/core/stochastic_rsi.sv @@
// Stochastic RSI top level: configuration register, front end, queue and back end.
// Start and accumulate items retire with no division; seed and smoothing items run
// the 48-step average and 23-step RSI divisions, emitting items also the 17-step
// output division, plus a window rescan when an expiring extreme forces one.
// Throughput is one item per back-end run; a two-entry queue absorbs input bursts.
// Reset is asynchronous and active low; the window memory is not cleared.
module stochastic_rsi import srsi_pkg::*; #(
  parameter int MAX_PERIOD = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [PRICE_BITS-1:0] price_i,
  input  logic                         series_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [OUT_W-1:0]             stoch_value_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int PW = $clog2(MAX_PERIOD+1);
  localparam int QW = $bits(srsi_ctl_t) + 2*PRICE_BITS + PW;

  logic [PERIOD_W-1:0]   period_q;
  logic                  q_full, q_empty, q_push, q_pop;
  srsi_ctl_t             f_ctl;
  logic [PRICE_BITS-1:0] f_up, f_down;
  logic [PW-1:0]         f_period;
  logic [QW-1:0]         q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PERIOD) ? APB_DW'(period_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_PERIOD) begin
      period_q <= pwdata[PERIOD_W-1:0];
    end
  end

  srsi_front #(
    .MAX_PERIOD (MAX_PERIOD),
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .price_i         (price_i),
    .series_start_i  (series_start_i),
    .period_length_i (period_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_ctl_o         (f_ctl),
    .q_up_o          (f_up),
    .q_down_o        (f_down),
    .q_period_o      (f_period)
  );

  srsi_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_ctl, f_up, f_down, f_period}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  srsi_back #(
    .MAX_PERIOD (MAX_PERIOD),
    .PRICE_BITS (PRICE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .q_ctl_i       (srsi_ctl_t'(q_rdata[QW-1 -: $bits(srsi_ctl_t)])),
    .q_up_i        (q_rdata[2*PRICE_BITS+PW-1 -: PRICE_BITS]),
    .q_down_i      (q_rdata[PRICE_BITS+PW-1 -: PRICE_BITS]),
    .q_period_i    (q_rdata[PW-1:0]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .stoch_value_o (stoch_value_o)
  );

endmodule

@@ rtl/core/srsi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/srsi_queue.sv @@
// Two-entry queue that decouples the front end from the back end.
// No dependencies.
module srsi_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] buf_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        buf_q[wptr_q] <= wdata_i;
        wptr_q        <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ rtl/core/srsi_front.sv @@
// Front end: accepts price items, forms up and down moves and classifies each item.
// Depends on srsi_pkg.
module srsi_front import srsi_pkg::*; #(
  parameter int MAX_PERIOD = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [PRICE_BITS-1:0]     price_i,
  input  logic                             series_start_i,
  input  logic [PERIOD_W-1:0]              period_length_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output srsi_ctl_t                        q_ctl_o,
  output logic [PRICE_BITS-1:0]            q_up_o,
  output logic [PRICE_BITS-1:0]            q_down_o,
  output logic [$clog2(MAX_PERIOD+1)-1:0]  q_period_o
);

  localparam int PW    = $clog2(MAX_PERIOD+1);
  localparam int CNT_W = $clog2(2*MAX_PERIOD+1);
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(2*MAX_PERIOD);

  logic [PRICE_BITS-1:0] prev_q;
  logic [CNT_W-1:0]      count_q;
  logic [PW-1:0]         act_p_q;

  logic                  accept, start;
  logic [PW-1:0]         p_clamp;
  logic [PRICE_BITS:0]   diff, neg_diff;
  logic [CNT_W-1:0]      p_ext, last_warm;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign start      = series_start_i || (count_q == '0);

  always_comb begin
    if (int'(period_length_i) < MIN_PERIOD) begin
      p_clamp = PW'(MIN_PERIOD);
    end else if (int'(period_length_i) > MAX_PERIOD) begin
      p_clamp = PW'(MAX_PERIOD);
    end else begin
      p_clamp = PW'(period_length_i);
    end
  end

  assign diff      = {price_i[PRICE_BITS-1], price_i} - {prev_q[PRICE_BITS-1], prev_q};
  assign neg_diff  = -diff;
  assign p_ext     = CNT_W'(act_p_q);
  assign last_warm = (p_ext << 1) - CNT_W'(1);

  always_comb begin
    q_push_o   = accept;
    q_period_o = start ? p_clamp : act_p_q;
    q_up_o     = '0;
    q_down_o   = '0;
    q_ctl_o    = '{op: OP_START, emit: 1'b0};
    if (!start) begin
      if (diff[PRICE_BITS]) begin
        q_down_o = neg_diff[PRICE_BITS-1:0];
      end else begin
        q_up_o = diff[PRICE_BITS-1:0];
      end
      if (count_q < p_ext) begin
        q_ctl_o.op = OP_ACCUM;
      end else if (count_q == p_ext) begin
        q_ctl_o.op = OP_SEED;
      end else begin
        q_ctl_o.op   = OP_SMOOTH;
        q_ctl_o.emit = (count_q >= last_warm);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      act_p_q <= PW'(MIN_PERIOD);
    end else if (accept) begin
      prev_q <= price_i;
      if (start) begin
        act_p_q <= p_clamp;
        count_q <= CNT_W'(1);
      end else if (count_q < COUNT_CAP) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/srsi_back.sv @@
// Back end: Wilder smoothing, RSI division, window max/min tracking and output division.
// Depends on srsi_pkg and srsi_ram.
module srsi_back import srsi_pkg::*; #(
  parameter int MAX_PERIOD = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  output logic                             q_pop_o,
  input  srsi_ctl_t                        q_ctl_i,
  input  logic [PRICE_BITS-1:0]            q_up_i,
  input  logic [PRICE_BITS-1:0]            q_down_i,
  input  logic [$clog2(MAX_PERIOD+1)-1:0]  q_period_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [OUT_W-1:0]                 stoch_value_o
);

  localparam int PW    = $clog2(MAX_PERIOD+1);
  localparam int AW    = $clog2(MAX_PERIOD);
  localparam int AF    = AVG_BITS - PRICE_BITS;
  localparam int SUM_W = PRICE_BITS + $clog2(MAX_PERIOD);
  localparam int AVG_W = (SUM_W > AVG_BITS) ? SUM_W : AVG_BITS;
  localparam int ND    = AVG_BITS + PW;
  localparam int MW    = AVG_BITS + 7;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_PREP  = 10'b0000000010,
    ST_DIVA  = 10'b0000000100,
    ST_RPREP = 10'b0000001000,
    ST_DIVR  = 10'b0000010000,
    ST_WIN   = 10'b0000100000,
    ST_SCAN  = 10'b0001000000,
    ST_OPREP = 10'b0010000000,
    ST_DIVO  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } srsi_state_e;

  srsi_state_e state_q, state_d;

  srsi_ctl_t             ctl_q;
  logic [PRICE_BITS-1:0] up_q, down_q;
  logic [PW-1:0]         p_q;
  logic [AVG_W-1:0]      gain_q, loss_q;
  logic [ND-1:0]         prod_g_q, prod_l_q;
  logic [PW-1:0]         drg_q, drl_q;
  logic [AVG_BITS-1:0]   dlg_q, dll_q;
  logic [AVG_BITS:0]     total_q, rrem_q;
  logic [RSI_W-1:0]      rlow_q, rsi_q, max_q, min_q, span_q, orem_q;
  logic [AW-1:0]         slot_q, cur_q, max_slot_q, min_slot_q, rd_idx_q;
  logic                  need_max_q, need_min_q, rd_vld_q;
  logic [PW-1:0]         scan_q;
  logic [OUT_W-1:0]      olow_q, res_q, out_value_q;
  logic                  out_valid_q;
  logic [STEP_W-1:0]     step_q;

  // Divider steps and helper values.
  logic [PW:0]           tg, tl, ng, nl;
  logic                  geg, gel;
  logic [AVG_BITS+1:0]   tr, nr;
  logic                  ger;
  logic [RSI_W:0]        to, nq;
  logic                  geo;
  logic [ND-1:0]         num_g, num_l;
  logic [AVG_BITS:0]     sum_gl;
  logic [MW-1:0]         a_pct;
  logic [PW-1:0]         slot_inc;
  logic [AW-1:0]         slot_next;
  logic [RSI_W-1:0]      rel;
  logic                  out_free;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RSI_W-1:0]      ram_rdata;

  assign tg  = {drg_q, dlg_q[AVG_BITS-1]};
  assign tl  = {drl_q, dll_q[AVG_BITS-1]};
  assign geg = (tg >= {1'b0, p_q});
  assign gel = (tl >= {1'b0, p_q});
  assign ng  = geg ? tg - {1'b0, p_q} : tg;
  assign nl  = gel ? tl - {1'b0, p_q} : tl;

  assign tr  = {rrem_q, rlow_q[RSI_W-1]};
  assign ger = (tr >= {1'b0, total_q});
  assign nr  = ger ? tr - {1'b0, total_q} : tr;

  assign to  = {orem_q, olow_q[OUT_W-1]};
  assign geo = (to >= {1'b0, span_q});
  assign nq  = geo ? to - {1'b0, span_q} : to;

  assign num_g = (ctl_q.op == OP_SEED) ? (ND'(gain_q) << AF) : prod_g_q + (ND'(up_q) << AF);
  assign num_l = (ctl_q.op == OP_SEED) ? (ND'(loss_q) << AF) : prod_l_q + (ND'(down_q) << AF);

  assign sum_gl = {1'b0, gain_q[AVG_BITS-1:0]} + {1'b0, loss_q[AVG_BITS-1:0]};
  assign a_pct  = MW'(gain_q[AVG_BITS-1:0]) * MW'(RSI_PCT);

  assign slot_inc  = PW'(slot_q) + PW'(1);
  assign slot_next = (slot_inc >= p_q) ? '0 : AW'(slot_inc);
  assign rel       = rsi_q - min_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign ram_we    = (state_q == ST_WIN);
  assign ram_waddr = (ctl_q.op == OP_SEED) ? '0 : slot_q;

  srsi_ram #(
    .WIDTH (RSI_W),
    .DEPTH (MAX_PERIOD)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rsi_q),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign q_pop_o       = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o   = out_valid_q;
  assign stoch_value_o = out_value_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && (q_ctl_i.op == OP_SEED || q_ctl_i.op == OP_SMOOTH)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP:  state_d = ST_DIVA;
      ST_DIVA:  if (step_q == '0) state_d = ST_RPREP;
      ST_RPREP: state_d = (sum_gl == '0) ? ST_WIN : ST_DIVR;
      ST_DIVR:  if (step_q == '0) state_d = ST_WIN;
      ST_WIN: begin
        if (ctl_q.op == OP_SEED) begin
          state_d = ST_IDLE;
        end else if ((!(rsi_q > max_q) && max_slot_q == slot_q) ||
                     (!(rsi_q < min_q) && min_slot_q == slot_q)) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ctl_q.emit ? ST_OPREP : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_q == p_q && !rd_vld_q) begin
          state_d = ctl_q.emit ? ST_OPREP : ST_IDLE;
        end
      end
      ST_OPREP: state_d = (max_q == min_q) ? ST_OUT : ST_DIVO;
      ST_DIVO:  if (step_q == '0) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= '0;
      loss_q      <= '0;
      slot_q      <= '0;
      max_q       <= '0;
      min_q       <= '0;
      max_slot_q  <= '0;
      min_slot_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            ctl_q  <= q_ctl_i;
            up_q   <= q_up_i;
            down_q <= q_down_i;
            p_q    <= q_period_i;
            case (q_ctl_i.op)
              OP_START: begin
                gain_q <= '0;
                loss_q <= '0;
                slot_q <= '0;
              end
              OP_ACCUM, OP_SEED: begin
                gain_q <= gain_q + AVG_W'(q_up_i);
                loss_q <= loss_q + AVG_W'(q_down_i);
              end
              OP_SMOOTH: begin
                prod_g_q <= ND'(gain_q[AVG_BITS-1:0]) * ND'(q_period_i - PW'(1));
                prod_l_q <= ND'(loss_q[AVG_BITS-1:0]) * ND'(q_period_i - PW'(1));
              end
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          drg_q  <= num_g[ND-1:AVG_BITS];
          dlg_q  <= num_g[AVG_BITS-1:0];
          drl_q  <= num_l[ND-1:AVG_BITS];
          dll_q  <= num_l[AVG_BITS-1:0];
          step_q <= STEP_W'(AVG_BITS-1);
        end
        ST_DIVA: begin
          drg_q  <= ng[PW-1:0];
          drl_q  <= nl[PW-1:0];
          dlg_q  <= {dlg_q[AVG_BITS-2:0], geg};
          dll_q  <= {dll_q[AVG_BITS-2:0], gel};
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            gain_q <= AVG_W'({dlg_q[AVG_BITS-2:0], geg});
            loss_q <= AVG_W'({dll_q[AVG_BITS-2:0], gel});
          end
        end
        ST_RPREP: begin
          // Zero total movement reads as an RSI of 50.
          total_q <= sum_gl;
          rrem_q  <= {1'b0, a_pct[MW-1:7]};
          rlow_q  <= {a_pct[6:0], {RSI_FRAC{1'b0}}};
          rsi_q   <= RSI_HALF;
          step_q  <= STEP_W'(RSI_W-1);
        end
        ST_DIVR: begin
          rrem_q <= nr[AVG_BITS:0];
          rlow_q <= {rlow_q[RSI_W-2:0], ger};
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            rsi_q <= {rlow_q[RSI_W-2:0], ger};
          end
        end
        ST_WIN: begin
          scan_q     <= '0;
          rd_vld_q   <= 1'b0;
          cur_q      <= slot_q;
          if (ctl_q.op == OP_SEED) begin
            need_max_q <= 1'b0;
            need_min_q <= 1'b0;
            slot_q     <= AW'(1);
            max_q      <= rsi_q;
            min_q      <= rsi_q;
            max_slot_q <= '0;
            min_slot_q <= '0;
          end else begin
            slot_q     <= slot_next;
            need_max_q <= !(rsi_q > max_q) && (max_slot_q == slot_q);
            need_min_q <= !(rsi_q < min_q) && (min_slot_q == slot_q);
            if (rsi_q > max_q) begin
              max_q      <= rsi_q;
              max_slot_q <= slot_q;
            end else if (max_slot_q == slot_q) begin
              // The maximum is being overwritten: rescan the rest of the ring.
              max_q      <= rsi_q;
            end
            if (rsi_q < min_q) begin
              min_q      <= rsi_q;
              min_slot_q <= slot_q;
            end else if (min_slot_q == slot_q) begin
              min_q      <= rsi_q;
            end
          end
        end
        ST_SCAN: begin
          if (scan_q < p_q) begin
            scan_q   <= scan_q + PW'(1);
            rd_vld_q <= 1'b1;
            rd_idx_q <= scan_q[AW-1:0];
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q && rd_idx_q != cur_q) begin
            if (need_max_q && ram_rdata > max_q) begin
              max_q      <= ram_rdata;
              max_slot_q <= rd_idx_q;
            end
            if (need_min_q && ram_rdata < min_q) begin
              min_q      <= ram_rdata;
              min_slot_q <= rd_idx_q;
            end
          end
        end
        ST_OPREP: begin
          span_q <= max_q - min_q;
          orem_q <= {1'b0, rel[RSI_W-1:1]};
          olow_q <= {rel[0], {RSI_FRAC{1'b0}}};
          res_q  <= '0;
          step_q <= STEP_W'(OUT_W-1);
        end
        ST_DIVO: begin
          orem_q <= nq[RSI_W-1:0];
          olow_q <= {olow_q[OUT_W-2:0], geo};
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            res_q <= {olow_q[OUT_W-2:0], geo};
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/srsi_checker.sv @@
// Port-level checker for the stochastic RSI block, bound to the top level.
// Depends on srsi_pkg.
module srsi_checker import srsi_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [OUT_W-1:0]  stoch_value_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready
);

  // A stalled result item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // The stochastic value never exceeds 1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stoch_value_o <= OUT_W'(65536))
    else $error("result above 1.0");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // A written period reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[2] == REG_PERIOD
    |=> paddr[2] != REG_PERIOD || prdata[PERIOD_W-1:0] == $past(pwdata[PERIOD_W-1:0]))
    else $error("period register readback mismatch");

endmodule

bind stochastic_rsi srsi_checker u_srsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .stoch_value_o (stoch_value_o),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
